// File: rtl/nat_pkg.sv
// Package for the note actuator tracker: action and command codes, field widths,
// reset values and the default actuator count. Used by every module of the block.
// It has no dependencies.
package nat_pkg;

   localparam int NOTE_COUNT_DEF = 32;

   localparam int ACTION_W = 3;
   localparam int NOTE_W   = 7;
   localparam int AMOUNT_W = 7;
   localparam int CMD_W    = 2;
   localparam int ACT_W    = 5;
   localparam int TOTAL_W  = 6;
   localparam int PROD_W   = 2 * AMOUNT_W;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [CMD_W-1:0]    command_type;
   typedef logic [NOTE_W-1:0]   note_type;
   typedef logic [AMOUNT_W-1:0] amount_type;
   typedef logic [ACT_W-1:0]    actuator_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   localparam action_type ACTION_NOTE_ON   = 3'd0;
   localparam action_type ACTION_NOTE_OFF  = 3'd1;
   localparam action_type ACTION_ALL_OFF   = 3'd2;
   localparam action_type ACTION_RESET_CTL = 3'd3;
   localparam action_type ACTION_VOLUME    = 3'd4;

   localparam command_type CMD_NONE    = 2'd0;
   localparam command_type CMD_PRESS   = 2'd1;
   localparam command_type CMD_RELEASE = 2'd2;

   localparam note_type   FIRST_NOTE_RESET = 7'd48;
   localparam amount_type VOLUME_FULL      = 7'd127;
   localparam total_type  TOTAL_MAX        = 6'd63;

endpackage

// File: rtl/nat_scaler.sv
// Velocity scaler: strength = (amount * volume) / 127, with the product and then the quotient registered.
// Depends on nat_pkg for widths and the full-scale constant.
module nat_scaler (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  nat_pkg::amount_type amount,
   input  nat_pkg::amount_type volume,
   output logic                done,
   output nat_pkg::amount_type scaled
);
   import nat_pkg::*;

   logic [PROD_W-1:0] product_ff;
   logic              busy_ff;
   logic              done_ff;
   amount_type        scaled_ff;
   amount_type        scaled_in;
   logic [PROD_W-1:0] sum;
   amount_type        est;
   logic [PROD_W-1:0] rem;

   // Estimate p/127 as (p + p/128) / 128, which is never high and at most one low;
   // a single compare of the remainder against 127 fixes it.
   always_comb begin
      sum       = product_ff + (product_ff >> AMOUNT_W);
      est       = sum[PROD_W-1:AMOUNT_W];
      rem       = product_ff - {est, {AMOUNT_W{1'b0}}} + PROD_W'(est);
      scaled_in = (rem >= PROD_W'(VOLUME_FULL)) ? est + 1'b1 : est;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= start;
         done_ff <= busy_ff;
      end
      if (start) begin
         product_ff <= amount * volume;
      end
      if (busy_ff) begin
         scaled_ff <= scaled_in;
      end
   end

   assign done   = done_ff;
   assign scaled = scaled_ff;

endmodule

// File: rtl/note_actuator_tracker.sv
// Top level of the note actuator tracker: event sequencer, active map, release scan
// and result register. Depends on nat_pkg and instantiates nat_scaler.
//
//   port group   direction   handshake              payload
//   req_         in          req_valid / req_stall  action, note, amount
//   rsp_         out         rsp_valid / rsp_stall  command .. final_res
//   csr_         in          csr_wr_en              first_note
//
// A note on goes from acceptance through the scaler (product, then quotient) to
// the result register; a note off goes straight to it. All notes off and reset
// controllers walk the active map one actuator a cycle while the result side
// does not stall. req_stall stays high until the item's last beat is loaded.
// A stalled result holds the sequencer only when it needs the result register.
// Reset is synchronous; it clears the map, count and valves and restores volume and first note.
module note_actuator_tracker #(
   parameter int NOTE_COUNT = nat_pkg::NOTE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nat_pkg::action_type   req_action,
   input  nat_pkg::note_type     req_note,
   input  nat_pkg::amount_type   req_amount,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nat_pkg::command_type  rsp_command,
   output nat_pkg::actuator_type rsp_actuator,
   output nat_pkg::amount_type   rsp_strength,
   output logic                  rsp_valve_low,
   output logic                  rsp_valve_high,
   output logic                  rsp_final_res,
   input  logic                  csr_wr_en,
   input  nat_pkg::note_type     csr_wr_data
);
   import nat_pkg::*;

   localparam int IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCALE = 3'd1;
   localparam logic [2:0] S_NOTE  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_LAST  = 3'd4;

   logic [2:0]            state_ff, state_in;
   action_type            action_ff, action_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [NOTE_COUNT-1:0] map_ff, map_in;
   total_type             total_ff, total_in;
   amount_type            volume_ff, volume_in;
   logic [1:0]            valves_ff, valves_in;
   note_type              first_ff, first_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   command_type           command_ff, command_in;
   actuator_type          actuator_ff, actuator_in;
   amount_type            strength_ff, strength_in;
   logic                  vlow_ff, vlow_in;
   logic                  vhigh_ff, vhigh_in;
   logic                  final_ff, final_in;

   logic                  accept;
   logic                  out_free;
   logic                  out_load;
   logic [NOTE_W:0]       diff;
   logic                  playable;
   logic [IDX_W-1:0]      rd_idx;
   logic                  hit;
   logic                  scale_start;
   logic                  scale_done;
   amount_type            scaled;
   total_type             total_next;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Window check: first_note <= note < first_note + NOTE_COUNT.
   assign diff     = {1'b0, req_note} - {1'b0, first_ff};
   assign playable = !diff[NOTE_W] && (diff[NOTE_W-1:0] < NOTE_W'(NOTE_COUNT));

   assign rd_idx = (state_ff == S_SCAN) ? scan_ff : idx_ff;
   assign hit    = map_ff[rd_idx];

   assign scale_start = accept && (req_action == ACTION_NOTE_ON) && playable;

   nat_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .amount (req_amount),
      .volume (volume_ff),
      .done   (scale_done),
      .scaled (scaled)
   );

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      map_in        = map_ff;
      total_in      = total_ff;
      volume_in     = volume_ff;
      valves_in     = valves_ff;
      first_in      = csr_wr_en ? csr_wr_data : first_ff;
      out_load      = 1'b0;
      command_in    = command_ff;
      actuator_in   = actuator_ff;
      strength_in   = strength_ff;
      vlow_in       = vlow_ff;
      vhigh_in      = vhigh_ff;
      final_in      = final_ff;
      total_next    = total_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               action_in = req_action;
               idx_in    = diff[IDX_W-1:0];
               case (req_action) inside
                  ACTION_NOTE_ON: begin
                     if (playable) begin
                        state_in = S_SCALE;
                     end
                  end
                  ACTION_NOTE_OFF: begin
                     if (playable) begin
                        state_in = S_NOTE;
                     end
                  end
                  ACTION_ALL_OFF, ACTION_RESET_CTL: begin
                     state_in      = S_SCAN;
                     scan_in       = '0;
                     pend_valid_in = 1'b0;
                  end
                  ACTION_VOLUME: begin
                     volume_in = req_amount;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCALE: begin
            if (scale_done) begin
               state_in = S_NOTE;
            end
         end
         S_NOTE: begin
            if (out_free) begin
               out_load    = 1'b1;
               actuator_in = ACT_W'(idx_ff);
               final_in    = 1'b1;
               if (action_ff == ACTION_NOTE_ON) begin
                  if (!hit) begin
                     map_in[idx_ff] = 1'b1;
                     if (total_ff != TOTAL_MAX) begin
                        total_in = total_ff + 1'b1;
                     end
                  end
                  valves_in   = {scaled[AMOUNT_W-1], 1'b1};
                  command_in  = CMD_PRESS;
                  strength_in = scaled;
               end else begin
                  if (hit) begin
                     map_in[idx_ff] = 1'b0;
                     if (total_ff != '0) begin
                        total_next = total_ff - 1'b1;
                     end
                  end
                  total_in = total_next;
                  if (total_next == '0) begin
                     valves_in = 2'b00;
                  end
                  command_in  = CMD_RELEASE;
                  strength_in = '0;
               end
               vlow_in  = valves_in[0];
               vhigh_in = valves_in[1];
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            // An active actuator is held back one step, so that the last one found
            // can be sent as the final beat with the valves closed.
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_load    = 1'b1;
                     command_in  = CMD_RELEASE;
                     actuator_in = ACT_W'(pend_ff);
                     strength_in = '0;
                     vlow_in     = valves_ff[0];
                     vhigh_in    = valves_ff[1];
                     final_in    = 1'b0;
                  end
                  pend_in         = scan_ff;
                  pend_valid_in   = 1'b1;
                  map_in[scan_ff] = 1'b0;
               end
               if (scan_ff == LAST_IDX) begin
                  state_in = S_LAST;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         S_LAST: begin
            if (out_free) begin
               out_load    = 1'b1;
               command_in  = pend_valid_ff ? CMD_RELEASE : CMD_NONE;
               actuator_in = pend_valid_ff ? ACT_W'(pend_ff) : '0;
               strength_in = '0;
               vlow_in     = 1'b0;
               vhigh_in    = 1'b0;
               final_in    = 1'b1;
               valves_in   = 2'b00;
               total_in    = '0;
               if (action_ff == ACTION_RESET_CTL) begin
                  volume_in = VOLUME_FULL;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         map_ff        <= '0;
         total_ff      <= '0;
         volume_ff     <= VOLUME_FULL;
         valves_ff     <= 2'b00;
         first_ff      <= FIRST_NOTE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         map_ff        <= map_in;
         total_ff      <= total_in;
         volume_ff     <= volume_in;
         valves_ff     <= valves_in;
         first_ff      <= first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      action_ff   <= action_in;
      idx_ff      <= idx_in;
      scan_ff     <= scan_in;
      pend_ff     <= pend_in;
      command_ff  <= command_in;
      actuator_ff <= actuator_in;
      strength_ff <= strength_in;
      vlow_ff     <= vlow_in;
      vhigh_ff    <= vhigh_in;
      final_ff    <= final_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command    = command_ff;
   assign rsp_actuator   = actuator_ff;
   assign rsp_strength   = strength_ff;
   assign rsp_valve_low  = vlow_ff;
   assign rsp_valve_high = vhigh_ff;
   assign rsp_final_res  = final_ff;

`ifndef NO_ASSERTIONS
   // The high valve never opens without the low valve.
   a_valve_order: assert property (@(posedge clock) disable iff (reset)
      !(valves_ff[1] && !valves_ff[0]))
      else $error("high valve open while low valve closed");

   // Between items the count matches the map, saturating at its maximum.
   a_total_matches_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         ((7'($countones(map_ff)) == 7'(total_ff)) ||
          ((7'($countones(map_ff)) == 7'(NOTE_COUNT)) && (total_ff == TOTAL_MAX))))
      else $error("active count disagrees with active map");

   // A finished release scan leaves no actuator active and the valves closed.
   a_scan_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAST) && (state_in == S_IDLE) |=>
         (map_ff == '0) && (valves_ff == 2'b00) && (total_ff == '0))
      else $error("release scan left state behind");

   // Every beat that ends an item leaves the sequencer idle.
   a_final_ends_item: assert property (@(posedge clock) disable iff (reset)
      out_load && final_in |=> (state_ff == S_IDLE))
      else $error("final beat loaded while item still in progress");
`endif

endmodule
